### rtl/core/mmpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmpa_pkg
// Shared widths, limits and the result word type of the multiproof index unit.
// ----------------------------------------------------------------------------
package mmpa_pkg;

   localparam int NODE_W  = 8;
   localparam int LEVEL_W = 3;
   localparam int TOTAL_W = 6;

   localparam logic [TOTAL_W-1:0] MAX_RESULTS = 6'd47;

   typedef struct packed {
      logic [LEVEL_W-1:0] auth_level;
      logic [NODE_W-1:0]  auth_index;
      logic               entry_valid;
      logic               last_entry;
      logic [TOTAL_W-1:0] total_count;
      logic               overflow;
   } result_type;

endpackage

### rtl/core/mmpa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mmpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/merkle_multiproof_auth_indices.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// merkle_multiproof_auth_indices
// Computes the sibling nodes a Merkle multiproof must carry for a leaf set.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one leaf index per word, ascending. A word with
//   req_last_leaf set is stored and then starts the level walk; req_ready
//   stays low until the walk is done. Loading accepts one leaf per cycle.
//   Leaves past LEAF_SLOTS are dropped and flag overflow for the run.
//   rsp_ channel: one word per needed sibling (level, index), the final one
//   with rsp_last_entry set; an empty set gives a single word with
//   rsp_entry_valid low. At most 47 words per run.
//   Walk: the walk reads each stored node once per level through one
//   RAM read port; one word is held back to tag the final one, so the
//   first result appears after the second sibling is found or the walk
//   ends.
//   A stalled receiver freezes the walk at the next emitted word; the
//   output register keeps its word and the walk resumes when it is taken.
//   Reset (synchronous) clears the leaf count, overflow flag and output.
// ----------------------------------------------------------------------------
module merkle_multiproof_auth_indices #(
   parameter int LEAF_SLOTS  = 8,
   parameter int TREE_LEVELS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [mmpa_pkg::NODE_W-1:0]   req_leaf_index,
   input  logic                          req_last_leaf,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [mmpa_pkg::LEVEL_W-1:0]  rsp_auth_level,
   output logic [mmpa_pkg::NODE_W-1:0]   rsp_auth_index,
   output logic                          rsp_entry_valid,
   output logic                          rsp_last_entry,
   output logic [mmpa_pkg::TOTAL_W-1:0]  rsp_total_count,
   output logic                          rsp_overflow
);
   import mmpa_pkg::*;

   localparam int IDX_W  = $clog2(LEAF_SLOTS);
   localparam int CNT_W  = $clog2(LEAF_SLOTS + 1);
   localparam int LVL_W  = (TREE_LEVELS > 2) ? $clog2(TREE_LEVELS) : 1;
   localparam int ADDR_W = IDX_W + 1;

   typedef enum logic [2:0] {
      S_IDLE, S_START, S_RD, S_EVAL, S_EMIT, S_NEXT, S_FIN
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               ovf_ff, ovf_in;
   logic [CNT_W-1:0]   len_ff, len_in;
   logic [CNT_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic               bank_ff, bank_in;
   logic [LVL_W-1:0]   lvl_ff, lvl_in;
   logic               pend_ff, pend_in;
   logic [NODE_W-1:0]  pnode_ff, pnode_in;
   logic [NODE_W-1:0]  nnode_ff, nnode_in;
   logic               endlvl_ff, endlvl_in;
   logic [NODE_W-1:0]  lpar_ff, lpar_in;
   logic               lpv_ff, lpv_in;
   logic [TOTAL_W-1:0] emit_cnt_ff, emit_cnt_in;
   logic               hold_v_ff, hold_v_in;
   result_type         hold_ff, hold_in;
   logic               out_v_ff, out_v_in;
   result_type         out_ff, out_in;

   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [NODE_W-1:0]  wr_data;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic [NODE_W-1:0]  rd_data;

   logic               app_req;
   logic [NODE_W-1:0]  app_par;
   logic               out_free;

   mmpa_ram #(
      .WIDTH (NODE_W),
      .DEPTH (2 ** ADDR_W)
   ) u_nodes (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free  = !out_v_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      ovf_in      = ovf_ff;
      len_in      = len_ff;
      rd_ptr_in   = rd_ptr_ff;
      wr_ptr_in   = wr_ptr_ff;
      bank_in     = bank_ff;
      lvl_in      = lvl_ff;
      pend_in     = pend_ff;
      pnode_in    = pnode_ff;
      nnode_in    = nnode_ff;
      endlvl_in   = endlvl_ff;
      lpar_in     = lpar_ff;
      lpv_in      = lpv_ff;
      emit_cnt_in = emit_cnt_ff;
      hold_v_in   = hold_v_ff;
      hold_in     = hold_ff;
      out_v_in    = out_v_ff && !rsp_ready;
      out_in      = out_ff;
      wr_en       = 1'b0;
      wr_addr     = {1'b0, cnt_ff[IDX_W-1:0]};
      wr_data     = req_leaf_index;
      rd_en       = 1'b0;
      rd_addr     = {bank_ff, rd_ptr_ff[IDX_W-1:0]};
      app_req     = 1'b0;
      app_par     = pnode_ff >> 1;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (cnt_ff < CNT_W'(LEAF_SLOTS)) begin
                  wr_en  = 1'b1;
                  cnt_in = cnt_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last_leaf) begin
                  state_in = S_START;
               end
            end
         end
         S_START: begin
            len_in      = cnt_ff;
            rd_ptr_in   = '0;
            wr_ptr_in   = '0;
            bank_in     = 1'b0;
            lvl_in      = '0;
            pend_in     = 1'b0;
            lpv_in      = 1'b0;
            emit_cnt_in = '0;
            hold_v_in   = 1'b0;
            state_in    = S_RD;
         end
         S_RD: begin
            if (rd_ptr_ff < len_ff) begin
               rd_en     = 1'b1;
               rd_ptr_in = rd_ptr_ff + 1'b1;
               state_in  = S_EVAL;
            end else if (pend_ff) begin
               endlvl_in = 1'b1;
               state_in  = S_EMIT;
            end else begin
               state_in = S_NEXT;
            end
         end
         S_EVAL: begin
            if (!pend_ff) begin
               pnode_in = rd_data;
               pend_in  = 1'b1;
               state_in = S_RD;
            end else if (rd_data == (pnode_ff ^ NODE_W'(1))) begin
               app_req  = 1'b1;
               pend_in  = 1'b0;
               state_in = S_RD;
            end else begin
               nnode_in  = rd_data;
               endlvl_in = 1'b0;
               state_in  = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!hold_v_ff || out_free) begin
               if (emit_cnt_ff == MAX_RESULTS) begin
                  state_in = S_FIN;
               end else begin
                  if (hold_v_ff) begin
                     out_v_in = 1'b1;
                     out_in   = hold_ff;
                  end
                  hold_v_in           = 1'b1;
                  hold_in.auth_level  = LEVEL_W'(lvl_ff);
                  hold_in.auth_index  = pnode_ff ^ NODE_W'(1);
                  hold_in.entry_valid = 1'b1;
                  hold_in.last_entry  = 1'b0;
                  hold_in.total_count = emit_cnt_ff + 1'b1;
                  hold_in.overflow    = ovf_ff;
                  emit_cnt_in         = emit_cnt_ff + 1'b1;
                  app_req             = 1'b1;
                  if (endlvl_ff) begin
                     pend_in  = 1'b0;
                     state_in = S_NEXT;
                  end else begin
                     pnode_in = nnode_ff;
                     state_in = S_RD;
                  end
               end
            end
         end
         S_NEXT: begin
            if (lvl_ff == LVL_W'(TREE_LEVELS - 1) || wr_ptr_ff == '0) begin
               state_in = S_FIN;
            end else begin
               lvl_in    = lvl_ff + 1'b1;
               bank_in   = !bank_ff;
               len_in    = wr_ptr_ff;
               rd_ptr_in = '0;
               wr_ptr_in = '0;
               lpv_in    = 1'b0;
               pend_in   = 1'b0;
               state_in  = S_RD;
            end
         end
         S_FIN: begin
            if (out_free) begin
               out_v_in = 1'b1;
               if (hold_v_ff) begin
                  out_in            = hold_ff;
                  out_in.last_entry = 1'b1;
               end else begin
                  out_in.auth_level  = '0;
                  out_in.auth_index  = '0;
                  out_in.entry_valid = 1'b0;
                  out_in.last_entry  = 1'b1;
                  out_in.total_count = '0;
                  out_in.overflow    = ovf_ff;
               end
               hold_v_in = 1'b0;
               cnt_in    = '0;
               ovf_in    = 1'b0;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // parent append into the other bank, adjacent duplicates dropped
      if (app_req && (!lpv_ff || lpar_ff != app_par)) begin
         wr_en     = 1'b1;
         wr_addr   = {!bank_ff, wr_ptr_ff[IDX_W-1:0]};
         wr_data   = app_par;
         wr_ptr_in = wr_ptr_ff + 1'b1;
         lpar_in   = app_par;
         lpv_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      len_ff      <= len_in;
      rd_ptr_ff   <= rd_ptr_in;
      wr_ptr_ff   <= wr_ptr_in;
      bank_ff     <= bank_in;
      lvl_ff      <= lvl_in;
      pend_ff     <= pend_in;
      pnode_ff    <= pnode_in;
      nnode_ff    <= nnode_in;
      endlvl_ff   <= endlvl_in;
      lpar_ff     <= lpar_in;
      lpv_ff      <= lpv_in;
      emit_cnt_ff <= emit_cnt_in;
      hold_ff     <= hold_in;
      out_ff      <= out_in;
      if (reset) begin
         state_ff  <= S_IDLE;
         cnt_ff    <= '0;
         ovf_ff    <= 1'b0;
         hold_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         ovf_ff    <= ovf_in;
         hold_v_ff <= hold_v_in;
         out_v_ff  <= out_v_in;
      end
   end

   assign rsp_valid       = out_v_ff;
   assign rsp_auth_level  = out_ff.auth_level;
   assign rsp_auth_index  = out_ff.auth_index;
   assign rsp_entry_valid = out_ff.entry_valid;
   assign rsp_last_entry  = out_ff.last_entry;
   assign rsp_total_count = out_ff.total_count;
   assign rsp_overflow    = out_ff.overflow;

endmodule

### rtl/core/mmpa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmpa_checker
// Port-level checks on the multiproof index unit, bound to the top level.
// ----------------------------------------------------------------------------
module mmpa_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          req_last_leaf,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [mmpa_pkg::NODE_W-1:0]   rsp_auth_index,
   input logic                          rsp_entry_valid,
   input logic                          rsp_last_entry,
   input logic [mmpa_pkg::TOTAL_W-1:0]  rsp_total_count
);
   import mmpa_pkg::*;

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_last_leaf_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_last_leaf) |=> !req_ready)
      else $error("block took a word during the walk");

   a_empty_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_entry_valid) |-> (rsp_last_entry && rsp_total_count == '0))
      else $error("empty-set word malformed");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_entry_valid)
         |-> (rsp_total_count != '0 && rsp_total_count <= MAX_RESULTS))
      else $error("entry count out of range");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready)
         |=> (rsp_valid && $stable(rsp_auth_index) && $stable(rsp_total_count)))
      else $error("stalled result word changed");

endmodule

bind merkle_multiproof_auth_indices mmpa_checker u_mmpa_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_last_leaf   (req_last_leaf),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_auth_index  (rsp_auth_index),
   .rsp_entry_valid (rsp_entry_valid),
   .rsp_last_entry  (rsp_last_entry),
   .rsp_total_count (rsp_total_count)
);
